>>> src/arwc_pkg.sv
// ----------------------------------------------------------------------------
// arwc_pkg
// Shared types and constants for the anti-replay window check.
// ----------------------------------------------------------------------------
package arwc_pkg;

    localparam int SEQ_W      = 64;   // packet sequence number width
    localparam int WINDOW_DEF = 64;   // default window size
    localparam int WINDOW_MAX = 64;   // largest supported window
    localparam int DIST_W     = 7;    // holds a distance or shift of 0..WINDOW_MAX
    localparam int VERDICT_W  = 3;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IN_ORDER  = 3'd0,
        VERDICT_FAR_JUMP  = 3'd1,
        VERDICT_LATE      = 3'd2,
        VERDICT_DUPLICATE = 3'd3,
        VERDICT_TOO_OLD   = 3'd4
    } t_verdict;

    typedef struct packed {
        logic     accept;
        t_verdict verdict;
    } t_result;

endpackage

>>> src/arwc_window.sv
// ----------------------------------------------------------------------------
// arwc_window
// Window state (next expected number, seen bitmap) and the combinational check.
// ----------------------------------------------------------------------------
module arwc_window #(
    parameter int WINDOW = arwc_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_update,
    input  logic [arwc_pkg::SEQ_W-1:0]  i_seq,
    output arwc_pkg::t_result           o_result
);

    localparam int BM_W   = WINDOW - 1;
    localparam int DIST_W = arwc_pkg::DIST_W;

    logic [arwc_pkg::SEQ_W-1:0] r_exp, n_exp;
    logic [BM_W-1:0]            r_bm, n_bm;

    logic [arwc_pkg::SEQ_W-1:0] ahead_dist, behind_dist;
    logic                       is_ahead, ahead_near, behind_near, hit;
    logic [DIST_W-1:0]          shift_amt, bit_pos;
    logic [BM_W-1:0]            shifted, bit_mask;

    always_comb begin
        is_ahead    = (i_seq >= r_exp);
        ahead_dist  = i_seq - r_exp;
        behind_dist = r_exp - i_seq;
        ahead_near  = (ahead_dist  < arwc_pkg::SEQ_W'(WINDOW));
        behind_near = (behind_dist < arwc_pkg::SEQ_W'(WINDOW));
        // distances below WINDOW fit in DIST_W bits, +1 cannot overflow
        shift_amt   = ahead_dist[DIST_W-1:0] + DIST_W'(1);
        bit_pos     = behind_dist[DIST_W-1:0] - DIST_W'(1);
        shifted     = r_bm << shift_amt;
        bit_mask    = BM_W'(1) << bit_pos;
        hit         = |(r_bm & bit_mask);
    end

    always_comb begin
        n_exp = r_exp;
        n_bm  = r_bm;
        o_result.accept  = 1'b0;
        o_result.verdict = arwc_pkg::VERDICT_TOO_OLD;
        if (is_ahead) begin
            n_exp = i_seq + arwc_pkg::SEQ_W'(1);
            o_result.accept = 1'b1;
            if (ahead_near) begin
                n_bm = shifted | BM_W'(1);
                o_result.verdict = arwc_pkg::VERDICT_IN_ORDER;
            end else begin
                n_bm = BM_W'(1);
                o_result.verdict = arwc_pkg::VERDICT_FAR_JUMP;
            end
        end else if (behind_near) begin
            if (hit) begin
                o_result.verdict = arwc_pkg::VERDICT_DUPLICATE;
            end else begin
                n_bm = r_bm | bit_mask;
                o_result.accept  = 1'b1;
                o_result.verdict = arwc_pkg::VERDICT_LATE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= '0;
            r_bm  <= '0;
        end else if (i_update) begin
            r_exp <= n_exp;
            r_bm  <= n_bm;
        end
    end

endmodule

>>> src/anti_replay_window_check.sv
// ----------------------------------------------------------------------------
// anti_replay_window_check
// Sliding-window anti-replay check on 64-bit packet sequence numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one sequence number per transfer on i_s_axis_tdata.
//   Master stream: one verdict per input transfer, in input order, carrying
//   the accept flag and a verdict code (in order, far jump, late first
//   arrival, duplicate, too old).
//   Pipeline: an accepted number is captured in the input register, checked
//   against the window there, its verdict registered in the result register.
//   Throughput: one number per cycle unless the master stream stalls. The
//   window state updates in the same cycle it is read, so each check sees
//   every earlier number; the 64-bit compare/subtract and the bitmap
//   shifter set the cycle path.
//   Stall: the input register and the result register each hold one item.
//   While the receiver holds o_m_axis_tready low with a result pending, the
//   input register fills and o_s_axis_tready then drops.
//   Reset (i_rst_n low, synchronous): next expected number and bitmap clear,
//   both pipeline registers empty.
// ----------------------------------------------------------------------------
module anti_replay_window_check #(
    parameter int WINDOW = arwc_pkg::WINDOW_DEF   // 2 .. 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [arwc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [63:0] seq_number
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [arwc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata   // [0] accept, [3:1] verdict,
                                                               // [7:4] zero
);

    // input register
    logic                         r_in_valid;
    logic [arwc_pkg::SEQ_W-1:0]   r_in_seq;
    // result register
    logic                         r_out_valid;
    arwc_pkg::t_result            r_out_result;

    arwc_pkg::t_result            check_result;
    logic                         advance;

    // result slot free this cycle: empty or being drained
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    arwc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (advance),
        .i_seq    (r_in_seq),
        .o_result (check_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_seq <= i_s_axis_tdata[arwc_pkg::SEQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= check_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        (arwc_pkg::OUT_TDATA_W - arwc_pkg::VERDICT_W - 1)'(0),
        r_out_result.verdict,
        r_out_result.accept
    };

endmodule
